// File: design/i2c_register_access_master_macros.svh
// Assertion macros for the I2C register access master
`ifndef I2C_REGISTER_ACCESS_MASTER_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define I2C_RA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define I2C_RA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/i2c_ra_pkg.sv
// Types, codes and segment tables of the I2C register access master
`timescale 1ns / 1ps
`default_nettype none

package i2c_ra_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] KIND_START  = 3'd0;
    localparam logic [2:0] KIND_RSTART = 3'd1;
    localparam logic [2:0] KIND_TX     = 3'd2;
    localparam logic [2:0] KIND_RX     = 3'd3;
    localparam logic [2:0] KIND_NACK   = 3'd4;
    localparam logic [2:0] KIND_STOP   = 3'd5;

    localparam logic [1:0] SEL_ADDR_W = 2'd0;
    localparam logic [1:0] SEL_REG    = 2'd1;
    localparam logic [1:0] SEL_DATA   = 2'd2;
    localparam logic [1:0] SEL_ADDR_R = 2'd3;

    localparam logic [0:0] REG_DEVICE_ADDRESS  = 1'd0;
    localparam logic [0:0] REG_TICKS_PER_PHASE = 1'd1;

    localparam logic [6:0]  DEVICE_ADDRESS_RESET  = 7'd104;
    localparam logic [15:0] TICKS_PER_PHASE_RESET = 16'd100;

    localparam int PADDR_WIDTH = 3;

    localparam logic [2:0] LAST_SEG_WRITE = 3'd4;
    localparam logic [2:0] LAST_SEG_READ  = 3'd7;
    localparam logic [4:0] TX_BITS_END    = 5'd16;
    localparam logic [4:0] RX_LAST_OFF    = 5'd15;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] target_reg;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } res_t;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [15:0] ticks_per_phase;
    } cfg_t;

    function automatic logic [2:0] seg_kind(input logic rd, input logic [2:0] seg);
        logic [2:0] k;
        k = KIND_STOP;
        if (rd)
        begin
            case (seg)
                3'd0:    k = KIND_START;
                3'd1:    k = KIND_TX;
                3'd2:    k = KIND_TX;
                3'd3:    k = KIND_RSTART;
                3'd4:    k = KIND_TX;
                3'd5:    k = KIND_RX;
                3'd6:    k = KIND_NACK;
                default: k = KIND_STOP;
            endcase
        end
        else
        begin
            case (seg)
                3'd0:    k = KIND_START;
                3'd1:    k = KIND_TX;
                3'd2:    k = KIND_TX;
                3'd3:    k = KIND_TX;
                default: k = KIND_STOP;
            endcase
        end
        return k;
    endfunction

    function automatic logic [1:0] seg_sel(input logic rd, input logic [2:0] seg);
        logic [1:0] s;
        case (seg)
            3'd1:    s = SEL_ADDR_W;
            3'd2:    s = SEL_REG;
            3'd3:    s = rd ? SEL_ADDR_W : SEL_DATA;
            3'd4:    s = SEL_ADDR_R;
            default: s = SEL_ADDR_W;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] kind_last_off(input logic [2:0] kind);
        logic [4:0] n;
        case (kind)
            KIND_START:  n = 5'd1;
            KIND_RSTART: n = 5'd2;
            KIND_TX:     n = 5'd17;
            KIND_RX:     n = 5'd15;
            KIND_NACK:   n = 5'd1;
            default:     n = 5'd2;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: design/i2c_ra_if.sv
// Valid/ready channel interfaces for command ticks and bus results
`timescale 1ns / 1ps
`default_nettype none

interface i2c_ra_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] target_reg;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, output op, output target_reg, output write_data,
                    output sda_in, input ready);
    modport sink (input valid, input op, input target_reg, input write_data,
                  input sda_in, output ready);
endinterface

interface i2c_ra_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;

    modport source (output valid, output scl_out, output sda_out, output sda_enable,
                    output busy_res, output done_res, output read_data, input ready);
    modport sink (input valid, input scl_out, input sda_out, input sda_enable,
                  input busy_res, input done_res, input read_data, output ready);
endinterface

`default_nettype wire

// File: design/i2c_ra_apb.sv
// APB configuration registers: device address and ticks per phase
`timescale 1ns / 1ps
`default_nettype none

module i2c_ra_apb
    import i2c_ra_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_WIDTH-1:0] paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready,
    output cfg_t                        cfg
);

    logic [6:0]  dev_addr_reg;
    logic [15:0] ticks_reg;
    logic        wr_en;
    logic [0:0]  reg_idx;

    assign reg_idx = paddr[2:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= DEVICE_ADDRESS_RESET;
            ticks_reg    <= TICKS_PER_PHASE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEVICE_ADDRESS:  dev_addr_reg <= pwdata[6:0];
                REG_TICKS_PER_PHASE: ticks_reg    <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DEVICE_ADDRESS:  prdata = {25'd0, dev_addr_reg};
            REG_TICKS_PER_PHASE: prdata = {16'd0, ticks_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.device_address  = dev_addr_reg;
    assign cfg.ticks_per_phase = ticks_reg;

endmodule

`default_nettype wire

// File: design/i2c_ra_seq.sv
// Bus phase sequencer: transaction state and per-tick line levels
`timescale 1ns / 1ps
`default_nettype none

module i2c_ra_seq
    import i2c_ra_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output res_t       res
);

    logic        busy_reg,  busy_next;
    logic        rd_reg,    rd_next;
    logic [2:0]  seg_reg,   seg_next;
    logic [4:0]  off_reg,   off_next;
    logic [15:0] tick_reg,  tick_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  hreg_reg,  hreg_next;
    logic [7:0]  hdata_reg, hdata_next;
    logic [7:0]  rx_reg,    rx_next;
    logic [2:0]  lines_reg, lines_next;

    logic        start;
    logic        done;
    logic [2:0]  kind;
    logic [1:0]  sel;
    logic [4:0]  last_off;
    logic [7:0]  tx_byte;
    logic        tx_bit;
    logic [15:0] tp;
    logic        phase_end;
    logic        seg_end;
    logic        last;
    logic [2:0]  lvl;
    logic [7:0]  shifted;

    assign start = !busy_reg && (item.op == OP_WRITE || item.op == OP_READ);

    always_comb
    begin
        busy_next  = busy_reg || start;
        rd_next    = start ? (item.op == OP_READ) : rd_reg;
        seg_next   = start ? 3'd0 : seg_reg;
        off_next   = start ? 5'd0 : off_reg;
        tick_next  = start ? 16'd0 : tick_reg;
        shift_next = start ? 8'd0 : shift_reg;
        hreg_next  = start ? item.target_reg : hreg_reg;
        hdata_next = start ? item.write_data : hdata_reg;
        rx_next    = rx_reg;

        kind     = seg_kind(rd_next, seg_next);
        sel      = seg_sel(rd_next, seg_next);
        last_off = kind_last_off(kind);

        case (sel)
            SEL_ADDR_W: tx_byte = {cfg.device_address, 1'b0};
            SEL_ADDR_R: tx_byte = {cfg.device_address, 1'b1};
            SEL_REG:    tx_byte = hreg_next;
            default:    tx_byte = hdata_next;
        endcase
        tx_bit = tx_byte[3'd7 - off_next[3:1]];

        case (kind)
            KIND_START:  lvl = (off_next == 5'd0) ? 3'b111 : 3'b101;
            KIND_RSTART: lvl = (off_next == 5'd0) ? 3'b011 :
                               (off_next == 5'd1) ? 3'b111 : 3'b101;
            KIND_TX:     lvl = (off_next < TX_BITS_END) ? {off_next[0], tx_bit, 1'b1}
                                                        : {off_next[0], 2'b10};
            KIND_RX:     lvl = {off_next[0], 2'b10};
            KIND_NACK:   lvl = {off_next[0], 2'b11};
            default:     lvl = (off_next == 5'd0) ? 3'b001 :
                               (off_next == 5'd1) ? 3'b101 : 3'b111;
        endcase

        tp        = (cfg.ticks_per_phase == 16'd0) ? 16'd1 : cfg.ticks_per_phase;
        phase_end = ({1'b0, tick_next} + 17'd1) >= {1'b0, tp};
        seg_end   = off_next == last_off;
        last      = seg_end && (seg_next == (rd_next ? LAST_SEG_READ : LAST_SEG_WRITE));
        shifted   = {shift_next[6:0], item.sda_in};
        done      = 1'b0;
        lines_next = lines_reg;

        if (busy_next)
        begin
            lines_next = lvl;
            if (phase_end)
            begin
                if (kind == KIND_RX && off_next[0])
                begin
                    shift_next = shifted;
                    if (off_next == RX_LAST_OFF)
                    begin
                        rx_next = shifted;
                    end
                end
                tick_next = 16'd0;
                if (last)
                begin
                    busy_next = 1'b0;
                    done      = 1'b1;
                end
                else if (seg_end)
                begin
                    seg_next = seg_next + 3'd1;
                    off_next = 5'd0;
                end
                else
                begin
                    off_next = off_next + 5'd1;
                end
            end
            else
            begin
                tick_next = tick_next + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            rd_reg    <= 1'b0;
            seg_reg   <= 3'd0;
            off_reg   <= 5'd0;
            tick_reg  <= 16'd0;
            shift_reg <= 8'd0;
            hreg_reg  <= 8'd0;
            hdata_reg <= 8'd0;
            rx_reg    <= 8'd0;
            lines_reg <= 3'b111;
        end
        else if (fire)
        begin
            busy_reg  <= busy_next;
            rd_reg    <= rd_next;
            seg_reg   <= seg_next;
            off_reg   <= off_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            hreg_reg  <= hreg_next;
            hdata_reg <= hdata_next;
            rx_reg    <= rx_next;
            lines_reg <= lines_next;
        end
    end

    assign res.scl_out    = lines_next[2];
    assign res.sda_out    = lines_next[1];
    assign res.sda_enable = lines_next[0];
    assign res.busy_res   = busy_next;
    assign res.done_res   = done;
    assign res.read_data  = rx_next;

endmodule

`default_nettype wire

// File: design/i2c_register_access_master.sv
// Top level of the I2C register access master
//
//   channel  direction  handshake            payload
//   in_ch    sink       valid/ready          op, target_reg, write_data, sda_in
//   out_ch   source     valid/ready          scl_out, sda_out, sda_enable, busy_res,
//                                            done_res, read_data
//   apb      slave      psel/penable/pready  paddr, pwdata, prdata
//
// One transfer in and one transfer out per clock when both sides flow.
// A transfer passes through the input register, then through the sequencer into the result register.
// Reset leaves the bus idle with SCL and SDA high and driven.
// A stalled result holds; one more transfer is taken into the input register.
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_register_access_master_macros.svh"

module i2c_register_access_master
    import i2c_ra_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    i2c_ra_in_if.sink                   in_ch,
    i2c_ra_out_if.source                out_ch,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_WIDTH-1:0] paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready
);

    cfg_t  cfg;
    item_t item_reg;
    logic  in_vld_reg;
    res_t  res;
    res_t  res_reg;
    logic  out_vld_reg;
    logic  advance;
    logic  fire;
    logic  in_take;

    assign advance     = !out_vld_reg || out_ch.ready;
    assign fire        = in_vld_reg && advance;
    assign in_ch.ready = !in_vld_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    i2c_ra_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2c_ra_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_vld_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.op         <= in_ch.op;
            item_reg.target_reg <= in_ch.target_reg;
            item_reg.write_data <= in_ch.write_data;
            item_reg.sda_in     <= in_ch.sda_in;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid      = out_vld_reg;
    assign out_ch.scl_out    = res_reg.scl_out;
    assign out_ch.sda_out    = res_reg.sda_out;
    assign out_ch.sda_enable = res_reg.sda_enable;
    assign out_ch.busy_res   = res_reg.busy_res;
    assign out_ch.done_res   = res_reg.done_res;
    assign out_ch.read_data  = res_reg.read_data;

    `I2C_RA_ASSERT_IMP(a_done_not_busy, out_ch.valid && out_ch.done_res, !out_ch.busy_res, "done with busy set")
    `I2C_RA_ASSERT_IMP(a_released_high, out_ch.valid && !out_ch.sda_enable, out_ch.sda_out, "released SDA not high")
    `I2C_RA_ASSERT_NXT(a_stall_keeps_item, in_vld_reg && !advance, in_vld_reg, "stalled item lost")
    `I2C_RA_ASSERT_NXT(a_fire_gives_result, fire, out_vld_reg, "computed result not presented")

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking bench for the I2C register access master: tick-accurate bus-level prediction
`timescale 1ns / 1ps

import i2c_ra_pkg::*;

class bus_tracker;
    logic [6:0]  dev_addr;
    logic [15:0] tpp;
    logic [6:0]  phase_no;
    logic [15:0] tick_cnt;
    logic [7:0]  rx_shift;
    logic        rd_mode;
    logic [7:0]  reg_hold;
    logic [7:0]  data_hold;
    logic [7:0]  rx_byte;
    logic        scl;
    logic        sda;
    logic        sda_en;
    res_t        expected_levels[$];
    int          fails;

    function new();
        dev_addr  = DEVICE_ADDRESS_RESET;
        tpp       = TICKS_PER_PHASE_RESET;
        phase_no  = '0;
        tick_cnt  = '0;
        rx_shift  = '0;
        rd_mode   = 1'b0;
        reg_hold  = '0;
        data_hold = '0;
        rx_byte   = '0;
        scl       = 1'b1;
        sda       = 1'b1;
        sda_en    = 1'b1;
        fails     = 0;
    endfunction

    function bit busy();
        return phase_no != 0;
    endfunction

    function int pending();
        return expected_levels.size();
    endfunction

    // Map the current phase number onto its segment, byte on the wire and offset
    function void locate(output logic [2:0] kind, output logic [7:0] tx_byte,
                         output int off, output bit last);
        int r;
        r = int'(phase_no) - 1;
        tx_byte = 8'h00;
        last = 1'b0;
        kind = KIND_STOP;
        off = 0;
        if (r < 2)
        begin
            kind = KIND_START;
            off = r;
        end
        else if (r < 20)
        begin
            kind = KIND_TX;
            tx_byte = {dev_addr, 1'b0};
            off = r - 2;
        end
        else if (r < 38)
        begin
            kind = KIND_TX;
            tx_byte = reg_hold;
            off = r - 20;
        end
        else if (!rd_mode)
        begin
            if (r < 56)
            begin
                kind = KIND_TX;
                tx_byte = data_hold;
                off = r - 38;
            end
            else
            begin
                kind = KIND_STOP;
                off = r - 56;
                last = (off == 2);
            end
        end
        else if (r < 41)
        begin
            kind = KIND_RSTART;
            off = r - 38;
        end
        else if (r < 59)
        begin
            kind = KIND_TX;
            tx_byte = {dev_addr, 1'b1};
            off = r - 41;
        end
        else if (r < 75)
        begin
            kind = KIND_RX;
            off = r - 59;
        end
        else if (r < 77)
        begin
            kind = KIND_NACK;
            off = r - 75;
        end
        else
        begin
            kind = KIND_STOP;
            off = r - 77;
            last = (off == 2);
        end
    endfunction

    function void note_tick(item_t it);
        logic [2:0] kind;
        logic [7:0] tx_byte;
        int         off;
        bit         last;
        bit         done;
        int         span;
        res_t       want;
        done = 1'b0;
        if (phase_no == 0 && (it.op == OP_WRITE || it.op == OP_READ))
        begin
            rd_mode   = (it.op == OP_READ);
            reg_hold  = it.target_reg;
            data_hold = it.write_data;
            rx_shift  = '0;
            tick_cnt  = '0;
            phase_no  = 7'd1;
        end
        if (phase_no != 0)
        begin
            locate(kind, tx_byte, off, last);
            scl = ((off % 2) == 1);
            sda = 1'b1;
            sda_en = 1'b1;
            case (kind)
                KIND_START:
                begin
                    scl = 1'b1;
                    sda = (off == 0);
                end
                KIND_RSTART:
                begin
                    scl = (off != 0);
                    sda = (off != 2);
                end
                KIND_TX:
                begin
                    if (off < 16)
                        sda = tx_byte[7 - off / 2];
                    else
                        sda_en = 1'b0;
                end
                KIND_RX:
                    sda_en = 1'b0;
                KIND_NACK:
                    sda = 1'b1;
                default:
                begin
                    scl = (off != 0);
                    sda = (off == 2);
                end
            endcase
            span = (tpp == 0) ? 1 : int'(tpp);
            if (int'(tick_cnt) + 1 >= span)
            begin
                if (kind == KIND_RX && (off % 2) == 1)
                begin
                    rx_shift = {rx_shift[6:0], it.sda_in};
                    if (off == 15)
                        rx_byte = rx_shift;
                end
                tick_cnt = '0;
                if (last)
                begin
                    phase_no = '0;
                    done = 1'b1;
                end
                else
                    phase_no = phase_no + 7'd1;
            end
            else
                tick_cnt = tick_cnt + 16'd1;
        end
        want.scl_out    = scl;
        want.sda_out    = sda;
        want.sda_enable = sda_en;
        want.busy_res   = (phase_no != 0);
        want.done_res   = done;
        want.read_data  = rx_byte;
        expected_levels.push_back(want);
    endfunction

    function void compare_field(string name, int want, int got);
        if (want != got)
        begin
            if (fails < 50)
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    function void check_levels(res_t got);
        res_t want;
        if (expected_levels.size() == 0)
        begin
            if (fails < 50)
                $display("%0t: unexpected transfer: expected none, actual %h", $time, got);
            fails++;
            return;
        end
        want = expected_levels.pop_front();
        compare_field("scl_out", want.scl_out, got.scl_out);
        compare_field("sda_out", want.sda_out, got.sda_out);
        compare_field("sda_enable", want.sda_enable, got.sda_enable);
        compare_field("busy_res", want.busy_res, got.busy_res);
        compare_field("done_res", want.done_res, got.done_res);
        compare_field("read_data", want.read_data, got.read_data);
    endfunction
endclass

module tb;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_WIDTH-1:0] paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    int gap_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;

    bus_tracker trk = new();

    i2c_ra_in_if  in_ch();
    i2c_ra_out_if out_ch();

    i2c_register_access_master i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.scl_out    = out_ch.scl_out;
            got.sda_out    = out_ch.sda_out;
            got.sda_enable = out_ch.sda_enable;
            got.busy_res   = out_ch.busy_res;
            got.done_res   = out_ch.done_res;
            got.read_data  = out_ch.read_data;
            trk.check_levels(got);
        end
    end

    function automatic logic [1:0] pick_op(input bit with_unused);
        case ($urandom_range(0, with_unused ? 2 : 1))
            0:       return OP_WRITE;
            1:       return OP_READ;
            default: return OP_UNUSED;
        endcase
    endfunction

    function automatic int pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 1;
        else if (r < 85)
            return $urandom_range(2, 3);
        else if (r < 92)
            return 0;
        return $urandom_range(4, 5);
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 25;
        endcase
    endfunction

    // sda_level 0 or 1 holds the line, anything else randomizes it
    function automatic item_t random_tick(input int noise_pct, input int sda_level);
        item_t it;
        it.op = OP_TICK;
        if ($urandom_range(0, 99) < noise_pct)
            it.op = pick_op(1'b1);
        it.target_reg = 8'($urandom);
        it.write_data = 8'($urandom);
        if (sda_level == 0 || sda_level == 1)
            it.sda_in = 1'(sda_level);
        else
            it.sda_in = 1'($urandom);
        return it;
    endfunction

    task automatic push_item(input item_t it);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= it.op;
        in_ch.target_reg <= it.target_reg;
        in_ch.write_data <= it.write_data;
        in_ch.sda_in     <= it.sda_in;
        do
            @(posedge clk);
        while (!in_ch.ready);
        trk.note_tick(it);
        items_sent++;
    endtask

    task automatic start_cmd(input logic [1:0] op, input logic [7:0] reg_a,
                             input logic [7:0] data);
        item_t it;
        it = random_tick(0, 2);
        it.op = op;
        it.target_reg = reg_a;
        it.write_data = data;
        push_item(it);
    endtask

    task automatic ride_out(input int noise_pct, input int sda_level);
        while (trk.busy())
            push_item(random_tick(noise_pct, sda_level));
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (trk.pending() != 0);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_WIDTH'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_DEVICE_ADDRESS)
            trk.dev_addr = value[6:0];
        else
            trk.tpp = value[15:0];
        @(posedge clk);
    endtask

    initial
    begin
        item_t it;
        int    n;
        int    waited;
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.op         <= OP_TICK;
        in_ch.target_reg <= '0;
        in_ch.write_data <= '0;
        in_ch.sda_in     <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 15;
        stall_pct = 15;

        // idle ticks, then a read under the reset settings
        it = random_tick(0, 2);
        it.op = OP_UNUSED;
        push_item(it);
        push_item(random_tick(0, 2));
        start_cmd(OP_READ, 8'h3C, 8'hA5);
        repeat (3) push_item(random_tick(0, 2));
        settle();

        // stretch the current phase to the longest, then collapse it
        write_reg(REG_TICKS_PER_PHASE, 32'd65535);
        repeat (3) push_item(random_tick(20, 2));
        settle();
        write_reg(REG_TICKS_PER_PHASE, 32'd0);
        ride_out(10, 1);
        settle();

        write_reg(REG_DEVICE_ADDRESS, 32'd0);
        write_reg(REG_TICKS_PER_PHASE, 32'd1);
        start_cmd(OP_WRITE, 8'hFF, 8'h00);
        ride_out(25, 2);
        start_cmd(OP_WRITE, 8'h00, 8'hFF);
        ride_out(0, 2);
        settle();

        write_reg(REG_DEVICE_ADDRESS, 32'd127);
        write_reg(REG_TICKS_PER_PHASE, 32'd2);
        start_cmd(OP_READ, 8'h00, 8'h00);
        ride_out(0, 0);
        start_cmd(OP_READ, 8'hFF, 8'hFF);
        ride_out(0, 1);

        while (items_sent < 650)
        begin
            settle();
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_DEVICE_ADDRESS, $urandom_range(0, 127));
            if ($urandom_range(0, 1) != 0)
                write_reg(REG_TICKS_PER_PHASE, pick_span());
            if (items_sent >= 560)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct = pick_rate();
                stall_pct = pick_rate();
            end
            n = $urandom_range(30, 150);
            repeat (n)
            begin
                if (items_sent >= 560)
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                if (trk.busy())
                    push_item(random_tick(4, 2));
                else if ($urandom_range(0, 9) < 8)
                    start_cmd(pick_op(1'b0), 8'($urandom), 8'($urandom));
                else
                    push_item(random_tick(15, 2));
            end
        end

        gap_pct = 0;
        stall_pct = 0;
        in_ch.valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (trk.pending() != 0 && waited < 2000);
        repeat (4) @(posedge clk);
        if (trk.fails == 0 && trk.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// File: files.f
+incdir+design
design/i2c_ra_pkg.sv
design/i2c_ra_if.sv
design/i2c_ra_apb.sv
design/i2c_ra_seq.sv
design/i2c_register_access_master.sv
tb/tb.sv
